>>> sv/tlc_pkg.sv
// Shared types and constants of the two-level cache tag block.
`timescale 1ns / 1ps
package tlc_pkg;

	// Replacement policy codes
	localparam logic [1:0] POL_FIFO = 2'd0;
	localparam logic [1:0] POL_LRU  = 2'd1;
	localparam logic [1:0] POL_LFU  = 2'd2;
	localparam logic [1:0] POL_ALT  = 2'd3;  // behaves as LRU

	// Configuration register indexes
	localparam logic CFG_L1_POLICY = 1'b0;
	localparam logic CFG_L2_POLICY = 1'b1;

	localparam int ADDR_W    = 64;
	localparam int L1_TAG_OW = 52;
	localparam int L2_TAG_OW = 49;
	localparam int CNT_W     = 32;
	localparam int RES_W     = 304;

	// Result item, last field (l1_hit) in the lowest bits
	typedef struct packed {
		logic [6:0]          pad;
		logic [CNT_W-1:0]    l2_evict_count;
		logic [CNT_W-1:0]    l2_miss_count;
		logic [CNT_W-1:0]    l2_hit_count;
		logic [CNT_W-1:0]    l1_evict_count;
		logic [CNT_W-1:0]    l1_miss_count;
		logic [CNT_W-1:0]    l1_hit_count;
		logic [L2_TAG_OW-1:0] l2_victim_tag;
		logic                l2_evicted;
		logic [L1_TAG_OW-1:0] l1_victim_tag;
		logic                l1_evicted;
		logic                l2_hit;
		logic                l1_hit;
	} result_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

endpackage

>>> sv/tlc_victim.sv
// Victim way selection for one set: first free way, else FIFO, LRU or LFU.
`timescale 1ns / 1ps
module tlc_victim #(
	parameter int WAYS = 8
) (
	input  logic [WAYS-1:0]                       vld,
	input  logic [WAYS-1:0][tlc_pkg::CNT_W-1:0]   last,
	input  logic [WAYS-1:0][tlc_pkg::CNT_W-1:0]   cnt,
	input  logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] fifo_ptr,
	input  logic [1:0]                            policy,
	output logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] victim,
	output logic                                  full
);
	import tlc_pkg::*;

	localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int P  = 1 << WW;

	logic [CNT_W-1:0] key [2*P];
	logic [WW-1:0]    idx [2*P];
	logic [WW-1:0]    free_way;

	always_comb begin
		full     = &vld;
		free_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (!vld[w]) free_way = WW'(w);
		end
		// min tree, left (lower way) wins on ties; padding leaves hold all ones
		for (int i = 0; i < P; i++) begin
			if (i < WAYS) key[P+i] = (policy == POL_LFU) ? cnt[i] : last[i];
			else key[P+i] = '1;
			idx[P+i] = WW'(i);
		end
		key[0] = '0;
		idx[0] = '0;
		for (int i = P - 1; i >= 1; i--) begin
			if (key[2*i+1] < key[2*i]) begin
				key[i] = key[2*i+1];
				idx[i] = idx[2*i+1];
			end else begin
				key[i] = key[2*i];
				idx[i] = idx[2*i];
			end
		end
		if (!full) victim = free_way;
		else if (policy == POL_FIFO) victim = fifo_ptr;
		else victim = idx[1];
	end

endmodule

>>> sv/two_level_set_assoc_cache_tags.sv
// Top level: two-level set-associative cache tag store with replacement and stats.
`timescale 1ns / 1ps
// Usage
//   s_tvalid/s_tready/s_tdata carry one item: a 64-bit byte address.
//   m_tvalid/m_tready/m_tdata carry one result item per address: hit flags,
//   eviction flags with victim tags, and the six saturating counters.
//   cfg_we/cfg_index/cfg_data write l1_policy (index 0) or l2_policy (index 1)
//   while no item is in flight; code 3 acts as LRU.
// Flow
//   Each level keeps one synchronous memory row per set (all ways: valid,
//   tag, last-use stamp, use count, FIFO pointer), read into a register and
//   written back whole. On an L1 hit the result is loaded after the L1 row
//   read; on an L1 miss the steps are L1 row read, L2 row read and update,
//   L1 fill, result load. s_tready rises in the same cycle as m_tvalid, so
//   no new address is taken while an item is in these row read-modify-write
//   steps.
// Reset
//   arst_n clears control state, then a clearing pass writes zero rows into
//   every set of both memories; s_tready stays low during it. Policies reset
//   to LRU.
// Stall
//   A finished result sits in the output register until m_tready; the next
//   item may be accepted and processed meanwhile and waits before its result.
module two_level_set_assoc_cache_tags #(
	parameter int L1_SETS       = 64,
	parameter int L1_WAYS       = 8,
	parameter int L1_LINE_BYTES = 64,
	parameter int L2_SETS       = 512,
	parameter int L2_WAYS       = 8,
	parameter int L2_LINE_BYTES = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [tlc_pkg::ADDR_W-1:0]   s_tdata,   // address
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// l1_hit, l2_hit, l1_evicted, l1_victim_tag, l2_evicted, l2_victim_tag,
	// l1_hit_count, l1_miss_count, l1_evict_count, l2_hit_count,
	// l2_miss_count, l2_evict_count, zero fill
	output logic [tlc_pkg::RES_W-1:0]    m_tdata,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [1:0]                   cfg_data
);
	import tlc_pkg::*;

	localparam int OB1  = $clog2(L1_LINE_BYTES);
	localparam int SB1  = $clog2(L1_SETS);
	localparam int SIW1 = (SB1 > 0) ? SB1 : 1;
	localparam int TW1  = ADDR_W - OB1 - SB1;
	localparam int WW1  = (L1_WAYS > 1) ? $clog2(L1_WAYS) : 1;
	localparam int OB2  = $clog2(L2_LINE_BYTES);
	localparam int SB2  = $clog2(L2_SETS);
	localparam int SIW2 = (SB2 > 0) ? SB2 : 1;
	localparam int TW2  = ADDR_W - OB2 - SB2;
	localparam int WW2  = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;
	localparam int CLR_ROWS = (L1_SETS > L2_SETS) ? L1_SETS : L2_SETS;
	localparam int CW   = $clog2(CLR_ROWS) + 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_L1   = 3'd1;
	localparam logic [2:0] ST_L2   = 3'd2;
	localparam logic [2:0] ST_F1   = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	typedef struct packed {
		logic [L1_WAYS-1:0]            vld;
		logic [L1_WAYS-1:0][TW1-1:0]   tag;
		logic [L1_WAYS-1:0][CNT_W-1:0] last;
		logic [L1_WAYS-1:0][CNT_W-1:0] cnt;
		logic [WW1-1:0]                fifo;
	} l1_row_t;

	typedef struct packed {
		logic [L2_WAYS-1:0]            vld;
		logic [L2_WAYS-1:0][TW2-1:0]   tag;
		logic [L2_WAYS-1:0][CNT_W-1:0] last;
		logic [L2_WAYS-1:0][CNT_W-1:0] cnt;
		logic [WW2-1:0]                fifo;
	} l2_row_t;

	// set memories
	l1_row_t l1_mem [L1_SETS];
	l2_row_t l2_mem [L2_SETS];
	l1_row_t l1_rd_s1;
	l2_row_t l2_rd_s1;
	logic    l1_we, l1_re, l2_we, l2_re;
	logic [SIW1-1:0] l1_waddr, l1_raddr;
	logic [SIW2-1:0] l2_waddr, l2_raddr;
	l1_row_t l1_wdata;
	l2_row_t l2_wdata;

	// control and payload registers
	logic [2:0]       state_q;
	logic             clearing_q;
	logic [CW-1:0]    clr_q;
	logic [1:0]       l1_pol_q, l2_pol_q;
	logic [CNT_W-1:0] l1_clk_q, l2_clk_q;
	logic [CNT_W-1:0] l1_hits_q, l1_miss_q, l1_evs_q, l2_hits_q, l2_miss_q, l2_evs_q;
	logic [TW1-1:0]   tag1_q;
	logic [SIW1-1:0]  set1_q;
	logic [TW2-1:0]   tag2_q;
	logic [SIW2-1:0]  set2_q;
	l1_row_t          l1_row_q;
	logic             r_l1_hit_q, r_l2_hit_q, r_l1_ev_q, r_l2_ev_q;
	logic [L1_TAG_OW-1:0] r_l1_vtag_q;
	logic [L2_TAG_OW-1:0] r_l2_vtag_q;
	logic             m_tvalid_q;
	result_t          m_res_q;

	// address split
	logic [ADDR_W-1:0] sh1, sh2, tsh1, tsh2;
	logic [SIW1-1:0]   set1;
	logic [SIW2-1:0]   set2;

	always_comb begin
		sh1  = s_tdata >> OB1;
		sh2  = s_tdata >> OB2;
		tsh1 = s_tdata >> (OB1 + SB1);
		tsh2 = s_tdata >> (OB2 + SB2);
		set1 = (SB1 > 0) ? sh1[SIW1-1:0] : '0;
		set2 = (SB2 > 0) ? sh2[SIW2-1:0] : '0;
	end

	// L1 probe on the row just read
	logic [L1_WAYS-1:0] l1_match;
	logic               l1_hit;
	logic [WW1-1:0]     l1_hway;
	l1_row_t            l1_hit_row;

	always_comb begin
		l1_hway = '0;
		for (int w = 0; w < L1_WAYS; w++)
			l1_match[w] = l1_rd_s1.vld[w] && (l1_rd_s1.tag[w] == tag1_q);
		for (int w = L1_WAYS - 1; w >= 0; w--)
			if (l1_match[w]) l1_hway = WW1'(w);
		l1_hit     = |l1_match;
		l1_hit_row = l1_rd_s1;
		if (l1_pol_q == POL_LRU) l1_hit_row.last[l1_hway] = l1_clk_q;
		else if (l1_pol_q == POL_LFU)
			l1_hit_row.cnt[l1_hway] = sat_inc(l1_rd_s1.cnt[l1_hway]);
	end

	// L2 probe and fill on the row just read
	logic [L2_WAYS-1:0] l2_match;
	logic               l2_hit;
	logic [WW2-1:0]     l2_hway, l2_vic;
	logic               l2_full;
	l2_row_t            l2_new_row;

	tlc_victim #(.WAYS(L2_WAYS)) u_vic2 (
		.vld     (l2_rd_s1.vld),
		.last    (l2_rd_s1.last),
		.cnt     (l2_rd_s1.cnt),
		.fifo_ptr(l2_rd_s1.fifo),
		.policy  (l2_pol_q),
		.victim  (l2_vic),
		.full    (l2_full)
	);

	always_comb begin
		l2_hway = '0;
		for (int w = 0; w < L2_WAYS; w++)
			l2_match[w] = l2_rd_s1.vld[w] && (l2_rd_s1.tag[w] == tag2_q);
		for (int w = L2_WAYS - 1; w >= 0; w--)
			if (l2_match[w]) l2_hway = WW2'(w);
		l2_hit     = |l2_match;
		l2_new_row = l2_rd_s1;
		if (l2_hit) begin
			if (l2_pol_q == POL_LRU) l2_new_row.last[l2_hway] = l2_clk_q;
			else if (l2_pol_q == POL_LFU)
				l2_new_row.cnt[l2_hway] = sat_inc(l2_rd_s1.cnt[l2_hway]);
		end else begin
			l2_new_row.vld[l2_vic]  = 1'b1;
			l2_new_row.tag[l2_vic]  = tag2_q;
			l2_new_row.last[l2_vic] = l2_clk_q;
			l2_new_row.cnt[l2_vic]  = (l2_pol_q == POL_LFU) ? CNT_W'(2) : CNT_W'(1);
			if (l2_full && l2_pol_q == POL_FIFO)
				l2_new_row.fifo = (l2_vic == WW2'(L2_WAYS - 1)) ? '0 : l2_vic + 1'b1;
		end
	end

	// L1 fill on the row kept from the probe
	logic [WW1-1:0] l1_vic;
	logic           l1_full;
	l1_row_t        l1_fill_row;

	tlc_victim #(.WAYS(L1_WAYS)) u_vic1 (
		.vld     (l1_row_q.vld),
		.last    (l1_row_q.last),
		.cnt     (l1_row_q.cnt),
		.fifo_ptr(l1_row_q.fifo),
		.policy  (l1_pol_q),
		.victim  (l1_vic),
		.full    (l1_full)
	);

	always_comb begin
		l1_fill_row              = l1_row_q;
		l1_fill_row.vld[l1_vic]  = 1'b1;
		l1_fill_row.tag[l1_vic]  = tag1_q;
		l1_fill_row.last[l1_vic] = l1_clk_q;
		l1_fill_row.cnt[l1_vic]  = (l1_pol_q == POL_LFU) ? CNT_W'(2) : CNT_W'(1);
		if (l1_full && l1_pol_q == POL_FIFO)
			l1_fill_row.fifo = (l1_vic == WW1'(L1_WAYS - 1)) ? '0 : l1_vic + 1'b1;
	end

	logic accept, out_free;
	assign s_tready = (state_q == ST_IDLE) && !clearing_q;
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// memory port control
	always_comb begin
		l1_we    = 1'b0;
		l1_waddr = set1_q;
		l1_wdata = l1_hit_row;
		l1_re    = accept;
		l1_raddr = set1;
		l2_we    = 1'b0;
		l2_waddr = set2_q;
		l2_wdata = l2_new_row;
		l2_re    = (state_q == ST_L1) && !l1_hit;
		l2_raddr = set2_q;
		if (clearing_q) begin
			l1_we    = clr_q < CW'(L1_SETS);
			l1_waddr = SIW1'(clr_q);
			l1_wdata = '0;
			l2_we    = clr_q < CW'(L2_SETS);
			l2_waddr = SIW2'(clr_q);
			l2_wdata = '0;
		end else begin
			if (state_q == ST_L1 && l1_hit) l1_we = 1'b1;
			if (state_q == ST_F1) begin
				l1_we    = 1'b1;
				l1_wdata = l1_fill_row;
			end
			if (state_q == ST_L2) l2_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (l1_we) l1_mem[l1_waddr] <= l1_wdata;
		if (l1_re) l1_rd_s1 <= l1_mem[l1_raddr];
	end

	always_ff @(posedge clk) begin
		if (l2_we) l2_mem[l2_waddr] <= l2_wdata;
		if (l2_re) l2_rd_s1 <= l2_mem[l2_raddr];
	end

	// payload registers
	logic [ADDR_W-1:0] l1_vt_ext, l2_vt_ext;
	always_comb begin
		l1_vt_ext = ADDR_W'(l1_row_q.tag[l1_vic]);
		l2_vt_ext = ADDR_W'(l2_rd_s1.tag[l2_vic]);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tag1_q <= tsh1[TW1-1:0];
			set1_q <= set1;
			tag2_q <= tsh2[TW2-1:0];
			set2_q <= set2;
		end
		if (state_q == ST_L1) begin
			l1_row_q    <= l1_rd_s1;
			r_l1_hit_q  <= l1_hit;
			r_l2_hit_q  <= 1'b0;
			r_l1_ev_q   <= 1'b0;
			r_l2_ev_q   <= 1'b0;
			r_l1_vtag_q <= '0;
			r_l2_vtag_q <= '0;
		end
		if (state_q == ST_L2) begin
			r_l2_hit_q <= l2_hit;
			if (!l2_hit && l2_full) begin
				r_l2_ev_q   <= 1'b1;
				r_l2_vtag_q <= l2_vt_ext[L2_TAG_OW-1:0];
			end
		end
		if (state_q == ST_F1 && l1_full) begin
			r_l1_ev_q   <= 1'b1;
			r_l1_vtag_q <= l1_vt_ext[L1_TAG_OW-1:0];
		end
		if (state_q == ST_DONE && out_free) begin
			m_res_q.pad            <= '0;
			m_res_q.l1_hit         <= r_l1_hit_q;
			m_res_q.l2_hit         <= r_l2_hit_q;
			m_res_q.l1_evicted     <= r_l1_ev_q;
			m_res_q.l1_victim_tag  <= r_l1_vtag_q;
			m_res_q.l2_evicted     <= r_l2_ev_q;
			m_res_q.l2_victim_tag  <= r_l2_vtag_q;
			m_res_q.l1_hit_count   <= l1_hits_q;
			m_res_q.l1_miss_count  <= l1_miss_q;
			m_res_q.l1_evict_count <= l1_evs_q;
			m_res_q.l2_hit_count   <= l2_hits_q;
			m_res_q.l2_miss_count  <= l2_miss_q;
			m_res_q.l2_evict_count <= l2_evs_q;
		end
	end

	// control state, clocks and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			clearing_q <= 1'b1;
			clr_q      <= '0;
			l1_pol_q   <= POL_LRU;
			l2_pol_q   <= POL_LRU;
			l1_clk_q   <= '0;
			l2_clk_q   <= '0;
			l1_hits_q  <= '0;
			l1_miss_q  <= '0;
			l1_evs_q   <= '0;
			l2_hits_q  <= '0;
			l2_miss_q  <= '0;
			l2_evs_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == CW'(CLR_ROWS - 1)) clearing_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_L1_POLICY: l1_pol_q <= (cfg_data == POL_ALT) ? POL_LRU : cfg_data;
					CFG_L2_POLICY: l2_pol_q <= (cfg_data == POL_ALT) ? POL_LRU : cfg_data;
					default: ;
				endcase
			end
			// load a new result, else drop the one just taken
			if (state_q == ST_DONE && out_free) m_tvalid_q <= 1'b1;
			else if (m_tvalid_q && m_tready) m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						l1_clk_q <= l1_clk_q + 1'b1;
						state_q  <= ST_L1;
					end
				end
				ST_L1: begin
					if (l1_hit) begin
						l1_hits_q <= sat_inc(l1_hits_q);
						state_q   <= ST_DONE;
					end else begin
						l1_miss_q <= sat_inc(l1_miss_q);
						l2_clk_q  <= l2_clk_q + 1'b1;
						state_q   <= ST_L2;
					end
				end
				ST_L2: begin
					if (l2_hit) l2_hits_q <= sat_inc(l2_hits_q);
					else begin
						l2_miss_q <= sat_inc(l2_miss_q);
						if (l2_full) l2_evs_q <= sat_inc(l2_evs_q);
					end
					state_q <= ST_F1;
				end
				ST_F1: begin
					if (l1_full) l1_evs_q <= sat_inc(l1_evs_q);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_res_q;

endmodule

>>> sv/tlc_checker.sv
// Port-level checks of the cache tag block, bound to the top level.
`timescale 1ns / 1ps
module tlc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [tlc_pkg::RES_W-1:0]  m_tdata
);
	import tlc_pkg::*;

	result_t res;
	assign res = m_tdata;

	// stalled result item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// only one item in flight
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item accepted during work");

	a_hits: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(res.l1_hit && res.l2_hit))
		else $error("both levels report a hit");

	a_nofill: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.l1_hit |-> !res.l1_evicted && !res.l2_evicted)
		else $error("eviction reported on an L1 hit");

	a_vtag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res.l1_evicted || res.l1_victim_tag == '0) &&
			(res.l2_evicted || res.l2_victim_tag == '0))
		else $error("victim tag without eviction");

endmodule

bind two_level_set_assoc_cache_tags tlc_checker u_tlc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> dv/two_level_set_assoc_cache_tags_checker.sv
// Result checker for the two-level cache tag block: predicts each access and compares.
`timescale 1ns / 1ps
module two_level_set_assoc_cache_tags_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic [tlc_pkg::ADDR_W-1:0] s_tdata,
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [tlc_pkg::RES_W-1:0]  m_tdata,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [1:0]                 cfg_data,
	output int                         fail_count,
	output int                         pending
);
	import tlc_pkg::*;

	localparam int W = 8;

	// L1 state
	logic         v1 [64*W];
	logic [51:0]  t1 [64*W];
	logic [31:0]  lu1 [64*W];
	logic [31:0]  uc1 [64*W];
	logic [2:0]   fp1 [64];
	logic [31:0]  clk1;
	// L2 state
	logic         v2 [512*W];
	logic [48:0]  t2 [512*W];
	logic [31:0]  lu2 [512*W];
	logic [31:0]  uc2 [512*W];
	logic [2:0]   fp2 [512];
	logic [31:0]  clk2;
	logic [31:0]  stats [6];
	logic [1:0]   pol1, pol2;

	result_t expected_results [$];

	function automatic logic [31:0] incsat(logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic logic [1:0] norm(logic [1:0] p);
		return (p == POL_ALT) ? POL_LRU : p;
	endfunction

	// probe of one level; lvl 0 is L1
	task automatic probe_level(input int lvl, input logic [1:0] p, input logic [63:0] a,
			output bit hit);
		int set;
		hit = 0;
		if (lvl == 0) begin
			clk1 = clk1 + 32'd1;
			set = int'(a[11:6]);
			for (int w = 0; w < W; w++)
				if (!hit && v1[set*W+w] && t1[set*W+w] == a[63:12]) begin
					hit = 1;
					stats[0] = incsat(stats[0]);
					if (p == POL_LRU) lu1[set*W+w] = clk1;
					else if (p == POL_LFU) uc1[set*W+w] = incsat(uc1[set*W+w]);
				end
			if (!hit) stats[1] = incsat(stats[1]);
		end else begin
			clk2 = clk2 + 32'd1;
			set = int'(a[14:6]);
			for (int w = 0; w < W; w++)
				if (!hit && v2[set*W+w] && t2[set*W+w] == a[63:15]) begin
					hit = 1;
					stats[3] = incsat(stats[3]);
					if (p == POL_LRU) lu2[set*W+w] = clk2;
					else if (p == POL_LFU) uc2[set*W+w] = incsat(uc2[set*W+w]);
				end
			if (!hit) stats[4] = incsat(stats[4]);
		end
	endtask

	task automatic fill_level(input int lvl, input logic [1:0] p, input logic [63:0] a,
			output bit ev, output logic [57:0] vt);
		int set, b, vic;
		bit found;
		logic [31:0] x, y;
		ev = 0; vt = '0; vic = 0; found = 0;
		set = (lvl == 0) ? int'(a[11:6]) : int'(a[14:6]);
		b = set * W;
		for (int w = 0; w < W; w++)
			if (!found && !((lvl == 0) ? v1[b+w] : v2[b+w])) begin
				vic = w; found = 1;
			end
		if (!found) begin
			if (p == POL_FIFO) begin
				if (lvl == 0) begin vic = int'(fp1[set]); fp1[set] = 3'(vic + 1); end
				else begin vic = int'(fp2[set]); fp2[set] = 3'(vic + 1); end
			end else begin
				for (int w = 1; w < W; w++) begin
					if (lvl == 0) begin
						x = (p == POL_LRU) ? lu1[b+w] : uc1[b+w];
						y = (p == POL_LRU) ? lu1[b+vic] : uc1[b+vic];
					end else begin
						x = (p == POL_LRU) ? lu2[b+w] : uc2[b+w];
						y = (p == POL_LRU) ? lu2[b+vic] : uc2[b+vic];
					end
					if (x < y) vic = w;
				end
			end
			ev = 1;
			if (lvl == 0) begin
				vt = 58'(t1[b+vic]); stats[2] = incsat(stats[2]);
			end else begin
				vt = 58'(t2[b+vic]); stats[5] = incsat(stats[5]);
			end
		end
		if (lvl == 0) begin
			v1[b+vic] = 1; t1[b+vic] = a[63:12]; lu1[b+vic] = clk1;
			uc1[b+vic] = (p == POL_LFU) ? 32'd2 : 32'd1;
		end else begin
			v2[b+vic] = 1; t2[b+vic] = a[63:15]; lu2[b+vic] = clk2;
			uc2[b+vic] = (p == POL_LFU) ? 32'd2 : 32'd1;
		end
	endtask

	task automatic predict_access(input logic [63:0] a);
		result_t r;
		bit h1, h2, e1, e2;
		logic [57:0] vt1, vt2;
		logic [1:0] p1, p2;
		p1 = norm(pol1); p2 = norm(pol2);
		h2 = 0; e1 = 0; e2 = 0; vt1 = '0; vt2 = '0;
		probe_level(0, p1, a, h1);
		if (!h1) begin
			probe_level(1, p2, a, h2);
			if (!h2) fill_level(1, p2, a, e2, vt2);
			fill_level(0, p1, a, e1, vt1);
		end
		r = '0;
		r.l1_hit = h1; r.l2_hit = h2;
		r.l1_evicted = e1; r.l1_victim_tag = vt1[51:0];
		r.l2_evicted = e2; r.l2_victim_tag = vt2[48:0];
		r.l1_hit_count = stats[0]; r.l1_miss_count = stats[1];
		r.l1_evict_count = stats[2]; r.l2_hit_count = stats[3];
		r.l2_miss_count = stats[4]; r.l2_evict_count = stats[5];
		expected_results = {expected_results, r};
	endtask

	task automatic report(input string f, input logic [63:0] e, input logic [63:0] g);
		if (fail_count < 10)
			$display("mismatch %s: expected %h got %h", f, e, g);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t got, exp_r;
		if (!arst_n) begin
			for (int i = 0; i < 64*W; i++) begin
				v1[i] = 0; t1[i] = '0; lu1[i] = '0; uc1[i] = '0;
			end
			for (int i = 0; i < 512*W; i++) begin
				v2[i] = 0; t2[i] = '0; lu2[i] = '0; uc2[i] = '0;
			end
			for (int i = 0; i < 64; i++) fp1[i] = '0;
			for (int i = 0; i < 512; i++) fp2[i] = '0;
			for (int i = 0; i < 6; i++) stats[i] = '0;
			clk1 = '0; clk2 = '0;
			pol1 = POL_LRU; pol2 = POL_LRU;
			fail_count = 0;
			expected_results.delete();
			pending = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_L1_POLICY) pol1 = cfg_data;
				else pol2 = cfg_data;
			end
			if (s_tvalid && s_tready) predict_access(s_tdata);
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata);
				if (expected_results.size() == 0) begin
					if (fail_count < 10) $display("result with none expected: %h", m_tdata);
					fail_count++;
				end else begin
					exp_r = expected_results.pop_front();
					if (got.l1_hit != exp_r.l1_hit) report("l1_hit", exp_r.l1_hit, got.l1_hit);
					if (got.l2_hit != exp_r.l2_hit) report("l2_hit", exp_r.l2_hit, got.l2_hit);
					if (got.l1_evicted != exp_r.l1_evicted)
						report("l1_evicted", exp_r.l1_evicted, got.l1_evicted);
					if (got.l1_victim_tag != exp_r.l1_victim_tag)
						report("l1_victim_tag", exp_r.l1_victim_tag, got.l1_victim_tag);
					if (got.l2_evicted != exp_r.l2_evicted)
						report("l2_evicted", exp_r.l2_evicted, got.l2_evicted);
					if (got.l2_victim_tag != exp_r.l2_victim_tag)
						report("l2_victim_tag", exp_r.l2_victim_tag, got.l2_victim_tag);
					if (got.l1_hit_count != exp_r.l1_hit_count)
						report("l1_hit_count", exp_r.l1_hit_count, got.l1_hit_count);
					if (got.l1_miss_count != exp_r.l1_miss_count)
						report("l1_miss_count", exp_r.l1_miss_count, got.l1_miss_count);
					if (got.l1_evict_count != exp_r.l1_evict_count)
						report("l1_evict_count", exp_r.l1_evict_count, got.l1_evict_count);
					if (got.l2_hit_count != exp_r.l2_hit_count)
						report("l2_hit_count", exp_r.l2_hit_count, got.l2_hit_count);
					if (got.l2_miss_count != exp_r.l2_miss_count)
						report("l2_miss_count", exp_r.l2_miss_count, got.l2_miss_count);
					if (got.l2_evict_count != exp_r.l2_evict_count)
						report("l2_evict_count", exp_r.l2_evict_count, got.l2_evict_count);
					if (got.pad != '0) report("pad", 0, got.pad);
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

>>> dv/two_level_set_assoc_cache_tags_test.sv
// Testbench top: drives addresses and policy writes into the cache tag block.
`timescale 1ns / 1ps
module two_level_set_assoc_cache_tags_test;
	import tlc_pkg::*;

	// no-handshake watchdog; its limit covers the clearing pass and long stalls
	localparam int STALL_LIMIT = 20000;

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 s_tvalid = 0;
	logic                 s_tready;
	logic [ADDR_W-1:0]    s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 0;
	logic [RES_W-1:0]     m_tdata;
	logic                 cfg_we = 0;
	logic                 cfg_index = 0;
	logic [1:0]           cfg_data = '0;
	int                   fail_count, pending;
	int                   send_idle_pct = 0, recv_idle_pct = 0;
	int                   quiet_cycles = 0;
	logic [63:0]          hot_lines [16];

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	two_level_set_assoc_cache_tags dut (.*);

	two_level_set_assoc_cache_tags_checker chk (.*);

	// receiver: random back-pressure per the current phase
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle_pct);

	// watchdog on accepted traffic
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// one address item, with optional idle cycles before it
	task automatic send_addr(input logic [63:0] a);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata  <= a;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_drain();
		s_tvalid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// policy write, only with the block empty
	task automatic write_policy(input logic idx, input logic [1:0] p);
		wait_drain();
		cfg_we    <= 1;
		cfg_index <= idx;
		cfg_data  <= p;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	// addresses mostly from a small pool of lines in few sets, so sets fill and evict
	function automatic logic [63:0] rand_addr();
		logic [63:0] a;
		int k;
		k = $urandom_range(99);
		if (k < 70) begin
			a = hot_lines[$urandom_range(15)];
			a[5:0] = 6'($urandom);
		end else if (k < 85) begin
			// same L1 set, many tags: L1 conflict pressure
			a = {$urandom, $urandom};
			a[14:6] = 9'h3;
		end else begin
			a = {$urandom, $urandom};
		end
		return a;
	endfunction

	initial begin
		for (int i = 0; i < 16; i++) begin
			hot_lines[i] = {$urandom, $urandom};
			hot_lines[i][14:6] = 9'($urandom_range(3));
		end
		repeat (9) @(posedge clk);
		arst_n <= 1;

		// directed: address extremes, then a set overfilled at L1
		send_idle_pct <= 37; recv_idle_pct <= 68;
		send_addr(64'h0);
		send_addr(64'hFFFF_FFFF_FFFF_FFFF);
		send_addr(64'h0);
		send_addr(64'hFFFF_FFFF_FFFF_FFC0);
		send_addr(64'hAAAA_AAAA_AAAA_AAAA);
		send_addr(64'h5555_5555_5555_5555);
		for (int i = 0; i < 10; i++)
			send_addr({52'(i + 1), 12'h040});
		// tags that share an L1 set but differ in L2 set
		for (int i = 0; i < 4; i++)
			send_addr({49'(7), 3'(i), 6'h1, 6'h0});
		send_addr({52'(1), 12'h040});

		// random phases over every policy code at both levels, extremes and the alias code
		for (int ph = 0; ph < 9; ph++) begin
			write_policy(CFG_L1_POLICY, 2'(ph % 4));
			write_policy(CFG_L2_POLICY, 2'((ph * 3 + 1) % 4));
			if (ph == 3) begin
				send_idle_pct <= 68; recv_idle_pct <= 37;
			end else if (ph == 6) begin
				send_idle_pct <= 0; recv_idle_pct <= 0;
			end
			for (int n = 0; n < 155; n++)
				send_addr(rand_addr());
		end

		wait_drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
